[rtl/gf5_pkg.sv]
// Shared types and constants for the 5x5 binomial RGB blur.
// No dependencies; every other file in rtl/ but gf5_checker imports this package.
package gf5_pkg;

    // Width of the line width register.
    localparam int LW_BITS = 11;

    // Smallest row width the window logic handles.
    localparam int MIN_WIDTH = 5;

    // Row count at which the window rows are all inside the frame (saturation point).
    localparam logic [2:0] ROW_FULL = 3'd4;

    // First column at which the window columns are all inside the frame.
    localparam int COL_EDGE = 4;

    // Largest value a filtered channel may take.
    localparam logic [7:0] CLAMP_MAX = 8'd254;

    // Output queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FILL_W     = 3;

    // One RGB pixel, red in the low byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // One row store word: a column of the last four rows, oldest row at index 0.
    typedef rgb_t [3:0] column_t;

    // Control tag that travels beside a beat in the pipeline.
    typedef struct packed {
        logic valid;
        logic win;
    } beat_tag_t;

    // One result beat.
    typedef struct packed {
        logic       window_valid;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } result_t;

endpackage

[rtl/gf5_lane.sv]
// One color lane of the blur: vertical binomial sum of the new column,
// a five-deep line of column sums, and the horizontal sum with clamp.
// Depends on gf5_pkg.
module gf5_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic [4:0][7:0] column,
    output logic [7:0]      smooth
);
    import gf5_pkg::*;

    localparam int VW = 12;
    localparam int HW = 16;

    logic [VW-1:0] vsum;
    logic [VW-1:0] vline_reg [5];
    logic [HW-1:0] hsum;
    logic [7:0]    scaled;

    // Vertical weights 1, 4, 6, 4, 1 built from shifts and adds.
    assign vsum = VW'(column[0])
                + (VW'(column[1]) << 2)
                + (VW'(column[2]) << 2) + (VW'(column[2]) << 1)
                + (VW'(column[3]) << 2)
                + VW'(column[4]);

    // Column sums of the window, oldest column at index 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
            begin
                vline_reg[k] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                vline_reg[k] <= vline_reg[k + 1];
            end
            vline_reg[4] <= vsum;
        end
    end

    // Horizontal weights, divide by 256 and clamp.
    assign hsum = HW'(vline_reg[0])
                + (HW'(vline_reg[1]) << 2)
                + (HW'(vline_reg[2]) << 2) + (HW'(vline_reg[2]) << 1)
                + (HW'(vline_reg[3]) << 2)
                + HW'(vline_reg[4]);

    assign scaled = hsum[HW-1:8];
    assign smooth = (scaled > CLAMP_MAX) ? CLAMP_MAX : scaled;

endmodule

[rtl/gf5_merge.sv]
// Merging stage: combines the three lane results and the window flag into
// one result beat and queues it in a small output FIFO.
// Depends on gf5_pkg.
module gf5_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gf5_pkg::beat_tag_t        tag,
    input  logic [7:0]                red_sum,
    input  logic [7:0]                green_sum,
    input  logic [7:0]                blue_sum,
    input  logic                      out_ready,
    output logic                      out_valid,
    output gf5_pkg::result_t          head,
    output logic [gf5_pkg::FILL_W-1:0] level
);
    import gf5_pkg::*;

    result_t              fifo_mem [FIFO_DEPTH];
    result_t              entry;
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]    level_reg;
    logic [FILL_W-1:0]    level_next;
    logic                 push;
    logic                 pop;

    // Build the entry; channels read zero outside a full window.
    always_comb
    begin
        entry.window_valid = tag.win;
        entry.red          = tag.win ? red_sum   : 8'd0;
        entry.green        = tag.win ? green_sum : 8'd0;
        entry.blue         = tag.win ? blue_sum  : 8'd0;
    end

    assign push      = tag.valid;
    assign out_valid = (level_reg != '0);
    assign pop       = out_valid & out_ready;
    assign head      = fifo_mem[rd_ptr_reg];
    assign level     = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + FILL_W'(1);
        end
        else if (!push && pop)
        begin
            level_next = level_reg - FILL_W'(1);
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            level_reg <= level_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

[rtl/gaussian_5x5_rgb_filter.sv]
// Top level of the 5x5 binomial RGB blur: counters, row store, window lanes.
// Depends on gf5_pkg, gf5_lane and gf5_merge.
//
// The block takes one RGB pixel per clock in raster order while in_ready is high
// and returns one result beat per pixel, in order, for the 5x5 window whose
// bottom-right corner is that pixel; the result belongs to the pixel two rows
// and two columns back. A beat passes the read and sum stage registers, then the
// output queue. The sustained rate of one pixel per clock without output stalls is
// set by the row store, a single memory of MAX_WIDTH words of four pixels that is
// read and written once per pixel, and by the four-entry output queue that absorbs
// output stalls. Channels are zero and window_valid is low until four rows and four
// columns of the current frame have gone by; border pixels are left to downstream.
// The row store needs no clearing after reset. line_width is clamped to 5..MAX_WIDTH
// and should be written only while the block is idle.
module gaussian_5x5_rgb_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gf5_pkg::LW_BITS-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  pixel_red,
    input  logic [7:0]                  pixel_green,
    input  logic [7:0]                  pixel_blue,
    input  logic                        frame_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  smooth_red,
    output logic [7:0]                  smooth_green,
    output logic [7:0]                  smooth_blue,
    output logic                        window_valid
);
    import gf5_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > LW_BITS) ? WW : LW_BITS;

    logic [LW_BITS-1:0] line_width_reg;
    logic [CMPW-1:0]    lw_ext;
    logic [CMPW-1:0]    w_eff;
    logic [CMPW-1:0]    col_inc;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_eff;
    logic [2:0]         row_reg;
    logic [2:0]         row_eff;
    logic               in_accept;
    logic               win_ok;

    logic               b_valid_reg;
    logic               b_win_reg;
    logic [CW-1:0]      b_col_reg;
    rgb_t               b_pix_reg;
    column_t            rd_reg;
    column_t            wr_word;
    rgb_t               col_vec [5];
    column_t            row_store [MAX_WIDTH];

    beat_tag_t          c_tag_reg;
    logic [4:0][7:0]    red_col;
    logic [4:0][7:0]    green_col;
    logic [4:0][7:0]    blue_col;
    logic [7:0]         red_sum;
    logic [7:0]         green_sum;
    logic [7:0]         blue_sum;
    result_t            head;
    logic [FILL_W-1:0]  level;
    logic [FILL_W-1:0]  pending;

    // Line width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LW_BITS'(640);
        end
        else if (cfg_we)
        begin
            line_width_reg <= cfg_wdata;
        end
    end

    // Width in effect, clamped to the supported range.
    assign lw_ext = CMPW'(line_width_reg);

    always_comb
    begin
        if (lw_ext < CMPW'(MIN_WIDTH))
        begin
            w_eff = CMPW'(MIN_WIDTH);
        end
        else if (lw_ext > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = lw_ext;
        end
    end

    // Position of the incoming pixel; a frame start clears it first.
    assign col_eff   = frame_start ? '0 : col_reg;
    assign row_eff   = frame_start ? '0 : row_reg;
    assign col_inc   = CMPW'(col_eff) + CMPW'(1);
    assign win_ok    = (row_eff >= ROW_FULL) && (CMPW'(col_eff) >= CMPW'(COL_EDGE));
    assign in_accept = in_valid & in_ready;

    // Column and row counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_eff < ROW_FULL) ? row_eff + 3'd1 : row_eff;
            end
            else
            begin
                col_reg <= CW'(col_inc);
                row_reg <= row_eff;
            end
        end
    end

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= in_accept;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_win_reg <= win_ok;
            b_col_reg <= col_eff;
            b_pix_reg <= '{blue: pixel_blue, green: pixel_green, red: pixel_red};
        end
    end

    // New window column: four stored rows plus the incoming pixel.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            col_vec[k] = rd_reg[k];
        end
        col_vec[4] = b_pix_reg;
        for (int k = 0; k < 4; k++)
        begin
            wr_word[k] = col_vec[k + 1];
        end
    end

    // Row store; a read of the address being written this cycle takes the new word.
    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            row_store[b_col_reg] <= wr_word;
        end
        if (in_accept)
        begin
            if (b_valid_reg && (b_col_reg == col_eff))
            begin
                rd_reg <= wr_word;
            end
            else
            begin
                rd_reg <= row_store[col_eff];
            end
        end
    end

    // Split the column into the three color lanes.
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            red_col[k]   = col_vec[k].red;
            green_col[k] = col_vec[k].green;
            blue_col[k]  = col_vec[k].blue;
        end
    end

    gf5_lane u_lane_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (b_valid_reg),
        .column   (red_col),
        .smooth   (red_sum)
    );

    gf5_lane u_lane_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (b_valid_reg),
        .column   (green_col),
        .smooth   (green_sum)
    );

    gf5_lane u_lane_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (b_valid_reg),
        .column   (blue_col),
        .smooth   (blue_sum)
    );

    // Sum stage tag, lined up with the lane outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_tag_reg <= '0;
        end
        else
        begin
            c_tag_reg.valid <= b_valid_reg;
            c_tag_reg.win   <= b_win_reg & b_valid_reg;
        end
    end

    gf5_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (c_tag_reg),
        .red_sum   (red_sum),
        .green_sum (green_sum),
        .blue_sum  (blue_sum),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .level     (level)
    );

    // Accept only while the queue has room for every beat still in flight.
    assign pending  = level + FILL_W'(b_valid_reg) + FILL_W'(c_tag_reg.valid);
    assign in_ready = (pending < FILL_W'(FIFO_DEPTH));

    assign smooth_red   = head.red;
    assign smooth_green = head.green;
    assign smooth_blue  = head.blue;
    assign window_valid = head.window_valid;

endmodule

[rtl/gf5_checker.sv]
// Port-level checks for the 5x5 binomial RGB blur, with the bind that attaches them.
// Depends on gaussian_5x5_rgb_filter's port list.
module gf5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  pixel_red,
    input logic [7:0]  pixel_green,
    input logic [7:0]  pixel_blue,
    input logic        frame_start,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  smooth_red,
    input logic [7:0]  smooth_green,
    input logic [7:0]  smooth_blue,
    input logic        window_valid
);

    // A waiting pixel beat holds its place and payload until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(pixel_red)
            && $stable(pixel_green) && $stable(pixel_blue) && $stable(frame_start))
        else $error("pixel beat changed while waiting");

    // A stalled result beat holds its place and payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smooth_red)
            && $stable(smooth_green) && $stable(smooth_blue) && $stable(window_valid))
        else $error("result beat changed while stalled");

    // Channels are zero when the window is not inside the frame.
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_valid |->
            smooth_red == 8'd0 && smooth_green == 8'd0 && smooth_blue == 8'd0)
        else $error("border beat carries nonzero channels");

    // The clamp keeps every channel at or below 254.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            smooth_red <= 8'd254 && smooth_green <= 8'd254 && smooth_blue <= 8'd254)
        else $error("channel above clamp limit");

endmodule

bind gaussian_5x5_rgb_filter gf5_checker u_gf5_checker (.*);

[test/gaussian_5x5_rgb_filter_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gaussian_5x5_rgb_filter: streams RGB frames at many row
// widths with random idling on both sides and checks each beat against a behavioral blur.
// Depends on gf5_pkg and the RTL of gaussian_5x5_rgb_filter.
module gaussian_5x5_rgb_filter_test;
    import gf5_pkg::*;

    localparam int          MAX_W         = 1024;
    localparam int unsigned RESET_WIDTH   = 640;
    localparam int unsigned IDLE_PCT      = 35;
    localparam int unsigned NOISE_ODDS    = 200;
    localparam int unsigned RANDOM_PIXELS = 300;
    localparam int unsigned WIDE_PIXELS   = 24;
    localparam int unsigned DRAIN_GAP     = 8;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned MAX_PRINTS    = 40;
    localparam int          DIR_ROWS      = 25;
    localparam result_t     NO_WINDOW     = '0;

    typedef enum int {CH_RED, CH_GREEN, CH_BLUE} channel_e;
    typedef enum int {PM_UNIFORM, PM_SATURATED, PM_EXTREME} pix_mode_e;

    // One row of the directed table; want is used only when known is set.
    typedef struct packed {
        rgb_t    pix;
        logic    frame;
        logic    known;
        result_t want;
    } stim_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [LW_BITS-1:0]   cfg_wdata    = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [7:0]           pixel_red    = '0;
    logic [7:0]           pixel_green  = '0;
    logic [7:0]           pixel_blue   = '0;
    logic                 frame_start  = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [7:0]           smooth_red;
    logic [7:0]           smooth_green;
    logic [7:0]           smooth_blue;
    logic                 window_valid;

    // Typed-in expectation that travels beside the pixel of a directed row.
    logic                 row_known    = 1'b0;
    result_t              row_expect   = '0;

    // Behavioral copy of the filter state.
    column_t              line_mem [MAX_W];
    rgb_t                 win [5][5];
    int unsigned          col_pos      = 0;
    int unsigned          rows_seen    = 0;
    logic [LW_BITS-1:0]   line_width_q = LW_BITS'(RESET_WIDTH);
    result_t              blur_exp_q [$];

    // Stimulus bookkeeping.
    stim_row_t            dir_table [DIR_ROWS];
    int unsigned          idle_pct     = IDLE_PCT;
    int unsigned          stall_pct    = IDLE_PCT;
    int unsigned          cur_eff      = RESET_WIDTH;
    logic                 need_frame   = 1'b0;
    int unsigned          pixels_sent  = 0;
    int unsigned          width_writes = 0;
    int unsigned          beats_checked = 0;
    int unsigned          windows_seen = 0;
    int unsigned          mismatches   = 0;
    int unsigned          cycle_count  = 0;

    gaussian_5x5_rgb_filter #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .smooth_red  (smooth_red),
        .smooth_green(smooth_green),
        .smooth_blue (smooth_blue),
        .window_valid(window_valid)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Row width in effect for a register value.
    function automatic int unsigned eff_width(input logic [LW_BITS-1:0] value);
        if (value < MIN_WIDTH)
            return MIN_WIDTH;
        if (value > MAX_W)
            return MAX_W;
        return 32'(value);
    endfunction

    // Binomial tap (1,4,6,4,1).
    function automatic int unsigned tap(input int idx);
        case (idx)
            0, 4:    return 1;
            1, 3:    return 4;
            default: return 6;
        endcase
    endfunction

    // Weighted sum of one channel over the current window, scaled and clamped.
    function automatic logic [7:0] blur_channel(input channel_e ch);
        int unsigned acc;
        logic [23:0] word;
        acc = 0;
        for (int r = 0; r < 5; r++)
        begin
            for (int k = 0; k < 5; k++)
            begin
                word = win[r][k];
                acc += word[8*ch +: 8] * tap(r) * tap(k);
            end
        end
        acc = acc >> 8;
        return (acc > CLAMP_MAX) ? CLAMP_MAX : 8'(acc);
    endfunction

    // Advance the behavioral filter by one pixel and return the beat it produces.
    function automatic result_t blur_step(input rgb_t pix, input logic fs);
        int unsigned w;
        int unsigned base;
        rgb_t col_in [5];
        result_t res;
        w = eff_width(line_width_q);
        if (fs)
        begin
            col_pos = 0;
            rows_seen = 0;
        end
        base = col_pos % MAX_W;
        for (int k = 0; k < 4; k++)
            col_in[k] = line_mem[base][k];
        col_in[4] = pix;

        // Slide the window one column and push the new column in on the right.
        for (int r = 0; r < 5; r++)
        begin
            for (int k = 0; k < 4; k++)
                win[r][k] = win[r][k+1];
            win[r][4] = col_in[r];
        end
        for (int k = 0; k < 4; k++)
            line_mem[base][k] = col_in[k+1];

        res = NO_WINDOW;
        if (rows_seen >= ROW_FULL && col_pos >= COL_EDGE)
        begin
            res.window_valid = 1'b1;
            res.red          = blur_channel(CH_RED);
            res.green        = blur_channel(CH_GREEN);
            res.blue         = blur_channel(CH_BLUE);
        end

        // A row ends at the last column, or at once if the width shrank under it.
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (rows_seen < ROW_FULL)
                rows_seen++;
        end
        else
        begin
            col_pos++;
        end
        return res;
    endfunction

    // Random pixel whose channels follow the chosen value distribution.
    function automatic rgb_t rand_pixel(input pix_mode_e mode);
        logic [23:0] word;
        logic [7:0] chan;
        word = '0;
        for (int c = 0; c < 3; c++)
        begin
            case (mode)
                PM_SATURATED: chan = ($urandom_range(9) != 0) ? 8'd255 : 8'($urandom_range(255));
                PM_EXTREME:   chan = ($urandom_range(1) != 0) ? 8'd255 - 8'($urandom_range(1))
                                                              : 8'($urandom_range(1));
                default:      chan = 8'($urandom_range(255));
            endcase
            word[8*c +: 8] = chan;
        end
        return word;
    endfunction

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] beat %0d: %s", $time, beats_checked, msg);
        mismatches++;
    endtask

    // Offer one pixel beat, after a random idle gap, and hold it until accepted.
    task automatic send_pixel(input rgb_t pix, input logic fs, input logic known,
                              input result_t want);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid    <= 1'b1;
        pixel_red   <= pix.red;
        pixel_green <= pix.green;
        pixel_blue  <= pix.blue;
        frame_start <= fs;
        row_known   <= known;
        row_expect  <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Send a run of random pixels; a pending width increase forces a new frame.
    task automatic send_run(input int unsigned count, input logic start_frame,
                            input logic noisy, input pix_mode_e mode);
        logic fs;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == 0)
                fs = start_frame || need_frame;
            else
                fs = noisy && ($urandom_range(NOISE_ODDS - 1) == 0);
            send_pixel(rand_pixel(mode), fs, 1'b0, NO_WINDOW);
        end
        need_frame = 1'b0;
        pixels_sent += count;
    endtask

    // Stop sending and wait until every expected beat has come out.
    task automatic drain_block;
        in_valid <= 1'b0;
        @(posedge clk);
        while (blur_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Write line_width once the block is idle.
    task automatic set_line_width(input logic [LW_BITS-1:0] value);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (eff_width(value) > cur_eff)
            need_frame = 1'b1;
        cur_eff = eff_width(value);
        width_writes++;
    endtask

    // Output side: random back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Track register writes and accepted pixels, and check every result beat.
    always @(posedge clk)
    begin : monitor
        result_t calc;
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_we)
                line_width_q = cfg_wdata;
            if (in_valid && in_ready)
            begin
                calc = blur_step({pixel_blue, pixel_green, pixel_red}, frame_start);
                if (row_known)
                    calc = row_expect;
                blur_exp_q.push_back(calc);
            end
            if (out_valid && out_ready)
            begin
                got = {window_valid, smooth_blue, smooth_green, smooth_red};
                if (blur_exp_q.size() == 0)
                begin
                    report_mismatch("result beat with no pixel waiting");
                end
                else
                begin
                    want = blur_exp_q.pop_front();
                    if (got.window_valid !== want.window_valid)
                        report_mismatch($sformatf("window_valid got %0b expected %0b",
                                                  got.window_valid, want.window_valid));
                    if (got.red !== want.red)
                        report_mismatch($sformatf("smooth_red got %0d expected %0d",
                                                  got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("smooth_green got %0d expected %0d",
                                                  got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("smooth_blue got %0d expected %0d",
                                                  got.blue, want.blue));
                    if (want.window_valid)
                        windows_seen++;
                end
                beats_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle %0d with %0d beats outstanding",
                     cycle_count, blur_exp_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main stimulus.
    initial
    begin : stimulus
        logic [LW_BITS-1:0] wval;
        int unsigned pick;
        int unsigned rand_base;
        pix_mode_e mode;

        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (win[r, k])
            win[r][k] = '0;

        // Directed frame at width 5: red saturated, green zero, blue sweeping extremes.
        // Every beat before the first full window is zero; the last one is predicted.
        dir_table[ 0] = '{'{8'd0,   8'd0, 8'd255}, 1'b1, 1'b1, NO_WINDOW};
        dir_table[ 1] = '{'{8'd255, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 2] = '{'{8'd128, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 3] = '{'{8'd1,   8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 4] = '{'{8'd254, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 5] = '{'{8'd64,  8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 6] = '{'{8'd192, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 7] = '{'{8'd32,  8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 8] = '{'{8'd224, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[ 9] = '{'{8'd16,  8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[10] = '{'{8'd240, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[11] = '{'{8'd8,   8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[12] = '{'{8'd248, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[13] = '{'{8'd4,   8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[14] = '{'{8'd252, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[15] = '{'{8'd2,   8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[16] = '{'{8'd253, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[17] = '{'{8'd127, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[18] = '{'{8'd129, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[19] = '{'{8'd85,  8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[20] = '{'{8'd170, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[21] = '{'{8'd51,  8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[22] = '{'{8'd204, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[23] = '{'{8'd255, 8'd0, 8'd255}, 1'b0, 1'b1, NO_WINDOW};
        dir_table[24] = '{'{8'd0,   8'd0, 8'd255}, 1'b0, 1'b0, NO_WINDOW};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset width: one row and two pixels, then narrow to the minimum mid-row.
        send_run(RESET_WIDTH + 2, 1'b1, 1'b0, PM_UNIFORM);
        set_line_width('0);
        send_run(30, 1'b0, 1'b0, PM_UNIFORM);

        // Directed table.
        drain_block();
        foreach (dir_table[i])
            send_pixel(dir_table[i].pix, dir_table[i].frame, dir_table[i].known,
                       dir_table[i].want);

        // A long stretch with no idling on either side.
        idle_pct  = 0;
        stall_pct = 0;

        // Width shrinks below the current column: that pixel closes the row.
        set_line_width(13);
        send_run(8 * 13 + 9, 1'b1, 1'b0, PM_UNIFORM);
        set_line_width(6);
        send_run(40, 1'b0, 1'b0, PM_SATURATED);

        // Register values above the widest row act as the widest row.
        set_line_width('1);
        send_run(WIDE_PIXELS, 1'b1, 1'b0, PM_UNIFORM);
        set_line_width(LW_BITS'(MAX_W + 1));
        send_run(WIDE_PIXELS, 1'b0, 1'b0, PM_EXTREME);
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;

        // Random phases: mostly whole frames with random content, a few stray frame starts.
        rand_base = pixels_sent;
        while (pixels_sent - rand_base < RANDOM_PIXELS)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                wval = LW_BITS'($urandom_range(MIN_WIDTH - 1, 0));
            else if (pick < 20)
                wval = LW_BITS'($urandom_range(64, 25));
            else
                wval = LW_BITS'($urandom_range(24, MIN_WIDTH));
            set_line_width(wval);
            mode = pix_mode_e'($urandom_range(2));
            if ($urandom_range(7) == 0)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = IDLE_PCT;
                stall_pct = IDLE_PCT;
            end
            send_run(cur_eff * $urandom_range(8, 5) + $urandom_range(cur_eff - 1),
                     1'($urandom_range(1)), 1'b1, mode);
        end

        drain_block();
        $display("Sent %0d pixels across %0d line_width writes, widths %0d to %0d.",
                 pixels_sent, width_writes, MIN_WIDTH, MAX_W);
        $display("Checked %0d beats, %0d of them full windows; %0d mismatches.",
                 beats_checked, windows_seen, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[gaussian_5x5_rgb_filter.f]
rtl/gf5_pkg.sv
rtl/gf5_lane.sv
rtl/gf5_merge.sv
rtl/gaussian_5x5_rgb_filter.sv
rtl/gf5_checker.sv
test/gaussian_5x5_rgb_filter_test.sv
